// ===== sv/brbp_pkg.sv =====
// Package for the banked RAM bitmap projection unit.
// Holds request/response types, register codes and RAM sizing.
// Depends on nothing; the decoder, the top level and the testbench use it.
`default_nettype none

package brbp_pkg;

   // RAM size in bytes, a power of two from 2 KiB to 256 KiB
   localparam int RAM_BYTES = 32768;
   localparam int RAM_AW    = $clog2(RAM_BYTES);

   localparam int ADDR_W    = 24;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 7;

   // Host window and bank geometry
   localparam logic [ADDR_W-1:0] HOST_WINDOW_END = 24'h002000;
   localparam int                BANK_AW         = 13;
   localparam logic [ADDR_W-1:0] PROTECT_BASE    = 24'h000100;
   localparam int                PROTECT_AW      = 18;

   typedef enum logic [1:0] {
      OP_HOST_READ  = 2'd0,
      OP_HOST_WRITE = 2'd1,
      OP_COP_READ   = 2'd2,
      OP_COP_WRITE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOST_BANK      = 3'd0,
      CSR_COP_BANK       = 3'd1,
      CSR_BITMAP_MODE    = 3'd2,
      CSR_TWO_BIT_PIXELS = 3'd3,
      CSR_COP_WRITE_EN   = 3'd4,
      CSR_HOST_WRITE_EN  = 3'd5,
      CSR_PROTECT_SHIFT  = 3'd6
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_ACCESS
   } state_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   write_data;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_data;
      logic                write_blocked;
   } rsp_type;

   typedef struct packed {
      logic [4:0] host_bank;
      logic [6:0] cop_bank;
      logic       bitmap_mode;
      logic       two_bit_pixels;
      logic       cop_write_enable;
      logic       host_write_enable;
      logic [3:0] protect_shift;
   } cfg_type;

   // Decoded access, handed from the address projection to the sequencer
   typedef struct packed {
      logic [RAM_AW-1:0] ram_addr;
      logic              is_write;
      logic              blocked;
      logic              pixel;
      logic              two_bit;
      logic [2:0]        pix_shift;
   } access_type;

endpackage

`default_nettype wire

// ===== sv/brbp_ram.sv =====
// Generic single-write, single-read synchronous byte RAM.
// Read data registered. No package dependency.
`default_nettype none

module brbp_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/brbp_decode.sv =====
// Address projection: host window remap, coprocessor linear/bitmap mapping,
// write protection check. Uses brbp_pkg types and constants.
`default_nettype none

module brbp_decode (
   input  wire brbp_pkg::req_type    req,
   input  wire brbp_pkg::cfg_type    cfg,
   output brbp_pkg::access_type      acc
);

   logic [brbp_pkg::ADDR_W-1:0]     host_a;
   logic [brbp_pkg::ADDR_W-1:0]     lin_a;
   logic [19:0]                     bmp_a;
   logic [brbp_pkg::ADDR_W-1:0]     bmp_byte;
   logic [brbp_pkg::ADDR_W-1:0]     full_a;
   logic [brbp_pkg::ADDR_W-1:0]     limit;
   logic                            prot_ok;
   logic                            is_cop;
   logic                            use_bitmap;

   assign is_cop     = (req.opcode == brbp_pkg::OP_COP_READ) ||
                       (req.opcode == brbp_pkg::OP_COP_WRITE);
   assign use_bitmap = is_cop && cfg.bitmap_mode;

   // Host window: low 8 KiB maps into the selected bank
   always_comb begin
      if (req.address < brbp_pkg::HOST_WINDOW_END) begin
         host_a = brbp_pkg::ADDR_W'({cfg.host_bank, req.address[brbp_pkg::BANK_AW-1:0]});
      end else begin
         host_a = req.address;
      end
   end

   // Coprocessor linear (32 banks) and bitmap (128 banks) projections
   assign lin_a = brbp_pkg::ADDR_W'({cfg.cop_bank[4:0], req.address[brbp_pkg::BANK_AW-1:0]});
   assign bmp_a = {cfg.cop_bank, req.address[brbp_pkg::BANK_AW-1:0]};

   always_comb begin
      if (cfg.two_bit_pixels) begin
         bmp_byte = brbp_pkg::ADDR_W'(bmp_a[19:2]);
      end else begin
         bmp_byte = brbp_pkg::ADDR_W'(bmp_a[19:1]);
      end
   end

   always_comb begin
      if (!is_cop) begin
         full_a = host_a;
      end else if (cfg.bitmap_mode) begin
         full_a = bmp_byte;
      end else begin
         full_a = lin_a;
      end
   end

   // Protection: both enables clear and low 18 bits under the limit
   assign limit   = brbp_pkg::PROTECT_BASE << cfg.protect_shift;
   assign prot_ok = cfg.cop_write_enable || cfg.host_write_enable ||
                    (brbp_pkg::ADDR_W'(full_a[brbp_pkg::PROTECT_AW-1:0]) >= limit);

   always_comb begin
      acc.ram_addr = full_a[brbp_pkg::RAM_AW-1:0];
      acc.pixel    = use_bitmap;
      acc.two_bit  = cfg.two_bit_pixels;
      if (cfg.two_bit_pixels) begin
         acc.pix_shift = {bmp_a[1:0], 1'b0};
      end else begin
         acc.pix_shift = {bmp_a[0], 2'b00};
      end
      acc.is_write = 1'b0;
      acc.blocked  = 1'b0;
      unique case (req.opcode)
         brbp_pkg::OP_HOST_WRITE: begin
            acc.is_write = prot_ok;
            acc.blocked  = !prot_ok;
         end
         brbp_pkg::OP_COP_WRITE: begin
            acc.is_write = use_bitmap || prot_ok;
            acc.blocked  = !use_bitmap && !prot_ok;
         end
         default: begin
            acc.is_write = 1'b0;
            acc.blocked  = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/banked_ram_bitmap_projection_unit.sv =====
// Top level of the banked RAM bitmap projection unit: config registers,
// access sequencer and response register. Uses brbp_pkg, brbp_decode, brbp_ram.
//
// Channel   Ports                              Direction  Handshake
// request   start, busy, req_data              in         start && !busy
// response  rsp_valid, rsp_data                out        one-cycle strobe
// config    csr_we, csr_index, csr_wdata       in         csr_we
//
// For each request, the accept edge issues the RAM read, the
// access cycle merges pixels and writes the byte back, and the response
// strobes in the following cycle while the next request can be accepted.
// The registered read of the synchronous RAM sets this order.
// Reset is synchronous; it clears the sequencer and the config registers.
// RAM contents are undefined until written. The receiver cannot stall.
`default_nettype none

module banked_ram_bitmap_projection_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire brbp_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   output brbp_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [brbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [brbp_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   brbp_pkg::cfg_type         cfg_ff;
   brbp_pkg::state_type       state_ff, state_in;
   brbp_pkg::access_type      dec_acc;
   brbp_pkg::access_type      acc_ff;
   logic [brbp_pkg::BYTE_W-1:0] wdata_ff;
   logic                      is_read_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   brbp_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                      accept;
   logic                      ram_we;
   logic [brbp_pkg::BYTE_W-1:0] ram_rdata;
   logic [brbp_pkg::BYTE_W-1:0] ram_wdata;
   logic [brbp_pkg::BYTE_W-1:0] pix_mask;
   logic [brbp_pkg::BYTE_W-1:0] field_mask;
   logic [brbp_pkg::BYTE_W-1:0] read_val;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            brbp_pkg::CSR_HOST_BANK:      cfg_ff.host_bank         <= csr_wdata[4:0];
            brbp_pkg::CSR_COP_BANK:       cfg_ff.cop_bank          <= csr_wdata[6:0];
            brbp_pkg::CSR_BITMAP_MODE:    cfg_ff.bitmap_mode       <= csr_wdata[0];
            brbp_pkg::CSR_TWO_BIT_PIXELS: cfg_ff.two_bit_pixels    <= csr_wdata[0];
            brbp_pkg::CSR_COP_WRITE_EN:   cfg_ff.cop_write_enable  <= csr_wdata[0];
            brbp_pkg::CSR_HOST_WRITE_EN:  cfg_ff.host_write_enable <= csr_wdata[0];
            brbp_pkg::CSR_PROTECT_SHIFT:  cfg_ff.protect_shift     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Address projection
   brbp_decode u_decode (
      .req (req_data),
      .cfg (cfg_ff),
      .acc (dec_acc)
   );

   assign busy   = (state_ff == brbp_pkg::ST_ACCESS);
   assign accept = start && !busy;

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brbp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      unique case (state_ff)
         brbp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = brbp_pkg::ST_ACCESS;
            end
         end
         brbp_pkg::ST_ACCESS: begin
            state_in     = brbp_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            ram_we       = acc_ff.is_write;
         end
         default: begin
            state_in = brbp_pkg::ST_IDLE;
         end
      endcase
   end

   // Request capture at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff     <= dec_acc;
         wdata_ff   <= req_data.write_data;
         is_read_ff <= (req_data.opcode == brbp_pkg::OP_HOST_READ) ||
                       (req_data.opcode == brbp_pkg::OP_COP_READ);
      end
   end

   // Byte store; read issued at accept, written back in the access cycle
   brbp_ram #(
      .ADDR_W (brbp_pkg::RAM_AW),
      .DATA_W (brbp_pkg::BYTE_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (acc_ff.ram_addr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (dec_acc.ram_addr),
      .rdata (ram_rdata)
   );

   // Pixel extract and merge
   assign pix_mask   = acc_ff.two_bit ? 8'h03 : 8'h0f;
   assign field_mask = pix_mask << acc_ff.pix_shift;

   always_comb begin
      if (acc_ff.pixel) begin
         read_val  = (ram_rdata >> acc_ff.pix_shift) & pix_mask;
         ram_wdata = (ram_rdata & ~field_mask) |
                     ((wdata_ff & pix_mask) << acc_ff.pix_shift);
      end else begin
         read_val  = ram_rdata;
         ram_wdata = wdata_ff;
      end
   end

   // Response register
   always_comb begin
      rsp_data_in.read_data     = is_read_ff ? read_val : '0;
      rsp_data_in.write_blocked = acc_ff.blocked;
   end

   always_ff @(posedge clock) begin
      if (state_ff == brbp_pkg::ST_ACCESS) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_accept_then_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("request accepted without a response two cycles later");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && !$past(rsp_valid))
      else $error("response strobe overlaps access or lasts two cycles");

   a_blocked_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_blocked |-> rsp_data.read_data == '0)
      else $error("blocked write returned nonzero read data");

   a_write_only_in_access: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> busy && !acc_ff.blocked)
      else $error("RAM written outside access cycle or for a blocked write");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for banked_ram_bitmap_projection_unit: host window, protection
// and linear/packed-pixel coprocessor access against a cycle-free model. Uses brbp_pkg.
module tb;

   localparam logic [brbp_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int MAX_GAP       = 12;
   localparam int PRINT_MAX     = 20;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 100;
   // Host addresses from here up are not remapped; the low bits pick the RAM byte
   localparam logic [brbp_pkg::ADDR_W-1:0] FILL_BASE = 24'h008000;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   brbp_pkg::req_type              req_data;
   logic                           rsp_valid;
   brbp_pkg::rsp_type              rsp_data;
   logic                           csr_we;
   logic [brbp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [brbp_pkg::CSR_DAT_W-1:0] csr_wdata;

   banked_ram_bitmap_projection_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the RAM and the config registers
   bit [7:0]          ram_shadow  [brbp_pkg::RAM_BYTES];
   bit                ram_written [brbp_pkg::RAM_BYTES];
   brbp_pkg::cfg_type cfg_shadow;

   brbp_pkg::rsp_type projected_results[$];
   brbp_pkg::req_type recent_writes[$];
   int                n_sent;
   int                n_checked;
   int                n_blocked;
   int                n_errors;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // RAM byte an access touches under the current register settings
   function automatic logic [brbp_pkg::RAM_AW-1:0] target_byte(brbp_pkg::req_type r);
      logic [31:0] a;
      if (r.opcode == brbp_pkg::OP_HOST_READ || r.opcode == brbp_pkg::OP_HOST_WRITE) begin
         a = {8'h00, r.address};
         if (a < 32'h2000)
            a = cfg_shadow.host_bank * 32'h2000 + (a & 32'h1fff);
      end else if (!cfg_shadow.bitmap_mode) begin
         a = cfg_shadow.cop_bank[4:0] * 32'h2000 + {19'b0, r.address[12:0]};
      end else begin
         a = (cfg_shadow.cop_bank * 32'h2000 + {19'b0, r.address[12:0]}) & 32'hfffff;
         a = cfg_shadow.two_bit_pixels ? (a >> 2) : (a >> 1);
      end
      return a[brbp_pkg::RAM_AW-1:0];
   endfunction

   // Reads and pixel writes depend on what the byte held before
   function automatic bit uses_old_byte(brbp_pkg::req_type r);
      return r.opcode == brbp_pkg::OP_HOST_READ || r.opcode == brbp_pkg::OP_COP_READ ||
             (r.opcode == brbp_pkg::OP_COP_WRITE && cfg_shadow.bitmap_mode);
   endfunction

   // Expected response of one access; updates the shadow RAM
   function automatic brbp_pkg::rsp_type project_access(brbp_pkg::req_type r);
      brbp_pkg::rsp_type res;
      logic [31:0]       a;
      logic [31:0]       byte_a;
      logic [31:0]       limit;
      logic [7:0]        cur;
      logic [7:0]        fmask;
      int unsigned       sh;
      bit                guarded;
      res     = '0;
      limit   = 32'h100 << cfg_shadow.protect_shift;
      guarded = !cfg_shadow.cop_write_enable && !cfg_shadow.host_write_enable;
      if (r.opcode == brbp_pkg::OP_HOST_READ || r.opcode == brbp_pkg::OP_HOST_WRITE) begin
         a = {8'h00, r.address};
         if (a < 32'h2000)
            a = cfg_shadow.host_bank * 32'h2000 + (a & 32'h1fff);
         if (r.opcode == brbp_pkg::OP_HOST_READ)
            res.read_data = ram_shadow[a[brbp_pkg::RAM_AW-1:0]];
         else if (guarded && (a & 32'h3ffff) < limit)
            res.write_blocked = 1'b1;
         else begin
            ram_shadow[a[brbp_pkg::RAM_AW-1:0]]  = r.write_data;
            ram_written[a[brbp_pkg::RAM_AW-1:0]] = 1'b1;
         end
      end else if (!cfg_shadow.bitmap_mode) begin
         // linear: 32 banks of bytes
         a = cfg_shadow.cop_bank[4:0] * 32'h2000 + {19'b0, r.address[12:0]};
         if (r.opcode == brbp_pkg::OP_COP_READ)
            res.read_data = ram_shadow[a[brbp_pkg::RAM_AW-1:0]];
         else if (guarded && (a & 32'h3ffff) < limit)
            res.write_blocked = 1'b1;
         else begin
            ram_shadow[a[brbp_pkg::RAM_AW-1:0]]  = r.write_data;
            ram_written[a[brbp_pkg::RAM_AW-1:0]] = 1'b1;
         end
      end else begin
         // bitmap: 128 banks of packed pixels, never protected
         a = (cfg_shadow.cop_bank * 32'h2000 + {19'b0, r.address[12:0]}) & 32'hfffff;
         if (cfg_shadow.two_bit_pixels) begin
            sh     = a[1:0] * 2;
            byte_a = a >> 2;
            fmask  = 8'h03;
         end else begin
            sh     = a[0] * 4;
            byte_a = a >> 1;
            fmask  = 8'h0f;
         end
         cur = ram_shadow[byte_a[brbp_pkg::RAM_AW-1:0]];
         if (r.opcode == brbp_pkg::OP_COP_READ)
            res.read_data = (cur >> sh) & fmask;
         else
            ram_shadow[byte_a[brbp_pkg::RAM_AW-1:0]] = (cur & ~(fmask << sh))
                                                     | ((r.write_data & fmask) << sh);
      end
      return res;
   endfunction

   function automatic brbp_pkg::req_type make_request(brbp_pkg::opcode_type op,
                                                      logic [brbp_pkg::ADDR_W-1:0] addr,
                                                      logic [7:0] data);
      brbp_pkg::req_type r;
      r.opcode     = op;
      r.address    = addr;
      r.write_data = data;
      return r;
   endfunction

   // An access that would see a never-written byte becomes a plain host write to it
   function automatic brbp_pkg::req_type defined_request(brbp_pkg::req_type r);
      logic [brbp_pkg::RAM_AW-1:0] idx;
      idx = target_byte(r);
      if (uses_old_byte(r) && !ram_written[idx])
         return make_request(brbp_pkg::OP_HOST_WRITE,
                             FILL_BASE | brbp_pkg::ADDR_W'(idx), r.write_data);
      return r;
   endfunction

   // Random request; address drawn from the host window, just above it, the whole
   // bus, near the protection limit, or a read-back of an earlier write
   function automatic brbp_pkg::req_type random_request();
      brbp_pkg::req_type r;
      brbp_pkg::req_type pick;
      logic [31:0]       lim;
      r.opcode     = brbp_pkg::opcode_type'($urandom_range(0, 3));
      r.write_data = 8'($urandom);
      case ($urandom_range(0, 5))
         0: r.address = {11'b0, 13'($urandom)};
         1: r.address = 24'($urandom);
         2: begin
            lim       = (32'h100 << cfg_shadow.protect_shift) - 2 + $urandom_range(0, 3);
            r.address = lim[brbp_pkg::ADDR_W-1:0];
         end
         3, 4: begin
            if (recent_writes.size() == 0) begin
               r.address = {11'b0, 13'($urandom)};
            end else begin
               pick      = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
               r.address = pick.address;
               if (pick.opcode == brbp_pkg::OP_HOST_WRITE)
                  r.opcode = brbp_pkg::OP_HOST_READ;
               else
                  r.opcode = brbp_pkg::OP_COP_READ;
            end
         end
         default: r.address = {11'b0, 13'($urandom)} | 24'h002000;
      endcase
      return r;
   endfunction

   // Send one request after a gap; leaves start high
   task automatic send_request(brbp_pkg::req_type r, int gap);
      brbp_pkg::req_type s;
      s = defined_request(r);
      if (s.opcode == brbp_pkg::OP_HOST_WRITE || s.opcode == brbp_pkg::OP_COP_WRITE)
         recent_writes.push_back(s);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (busy);
      projected_results.push_back(project_access(s));
      n_sent++;
   endtask

   task automatic do_access(brbp_pkg::opcode_type op, logic [brbp_pkg::ADDR_W-1:0] addr,
                            logic [7:0] data);
      send_request(make_request(op, addr, data), $urandom_range(0, MAX_GAP));
   endtask

   // Stop sending and wait for every pending response
   task automatic drain();
      start <= 1'b0;
      while (projected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [brbp_pkg::CSR_IDX_W-1:0] idx,
                                 logic [brbp_pkg::CSR_DAT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         brbp_pkg::CSR_HOST_BANK:      cfg_shadow.host_bank         = val[4:0];
         brbp_pkg::CSR_COP_BANK:       cfg_shadow.cop_bank          = val[6:0];
         brbp_pkg::CSR_BITMAP_MODE:    cfg_shadow.bitmap_mode       = val[0];
         brbp_pkg::CSR_TWO_BIT_PIXELS: cfg_shadow.two_bit_pixels    = val[0];
         brbp_pkg::CSR_COP_WRITE_EN:   cfg_shadow.cop_write_enable  = val[0];
         brbp_pkg::CSR_HOST_WRITE_EN:  cfg_shadow.host_write_enable = val[0];
         brbp_pkg::CSR_PROTECT_SHIFT:  cfg_shadow.protect_shift     = val[3:0];
         default: ;
      endcase
   endtask

   task automatic load_registers(int hb, int cb, int bm, int two, int cwe, int hwe, int ps);
      write_register(brbp_pkg::CSR_HOST_BANK,      brbp_pkg::CSR_DAT_W'(hb));
      write_register(brbp_pkg::CSR_COP_BANK,       brbp_pkg::CSR_DAT_W'(cb));
      write_register(brbp_pkg::CSR_BITMAP_MODE,    brbp_pkg::CSR_DAT_W'(bm));
      write_register(brbp_pkg::CSR_TWO_BIT_PIXELS, brbp_pkg::CSR_DAT_W'(two));
      write_register(brbp_pkg::CSR_COP_WRITE_EN,   brbp_pkg::CSR_DAT_W'(cwe));
      write_register(brbp_pkg::CSR_HOST_WRITE_EN,  brbp_pkg::CSR_DAT_W'(hwe));
      write_register(brbp_pkg::CSR_PROTECT_SHIFT,  brbp_pkg::CSR_DAT_W'(ps));
   endtask

   // Host window remap at both bank extremes and the window edges
   task automatic test_host_window();
      load_registers(31, 0, 0, 0, 0, 1, 0);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h008000, 8'h3c);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h000000, 8'hff);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h001fff, 8'h00);
      do_access(brbp_pkg::OP_HOST_READ,  24'h000000, 8'h00);
      do_access(brbp_pkg::OP_HOST_READ,  24'h001fff, 8'hff);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h002000, 8'ha5);
      do_access(brbp_pkg::OP_HOST_READ,  24'hffffff, 8'h00);
      drain();
      load_registers(0, 0, 0, 0, 0, 1, 0);
      do_access(brbp_pkg::OP_HOST_READ,  24'h000000, 8'h00);
      drain();
   endtask

   // Write protection: both limits, linear and bitmap coprocessor, enable lifted
   task automatic test_protection();
      load_registers(0, 0, 0, 0, 0, 0, 0);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h0000ff, 8'h11);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h000100, 8'h22);
      do_access(brbp_pkg::OP_COP_WRITE,  24'h000000, 8'h33);
      drain();
      load_registers(0, 0, 0, 0, 0, 0, 15);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'hffffff, 8'h44);
      drain();
      load_registers(0, 0, 1, 0, 0, 0, 15);
      do_access(brbp_pkg::OP_COP_WRITE,  24'h000000, 8'h05);
      drain();
      load_registers(0, 0, 0, 0, 1, 0, 15);
      do_access(brbp_pkg::OP_HOST_WRITE, 24'h000000, 8'h66);
      do_access(brbp_pkg::OP_COP_READ,   24'h000000, 8'h00);
      drain();
   endtask

   // Packed pixels: every pixel position in both formats, bank extremes
   task automatic test_bitmap();
      load_registers(0, 127, 1, 0, 0, 0, 0);
      do_access(brbp_pkg::OP_COP_WRITE, 24'h001fff, 8'hff);
      do_access(brbp_pkg::OP_COP_READ,  24'h001ffe, 8'h00);
      do_access(brbp_pkg::OP_COP_READ,  24'h001fff, 8'h00);
      drain();
      load_registers(0, 0, 1, 1, 0, 0, 0);
      do_access(brbp_pkg::OP_COP_WRITE, 24'h000000, 8'hff);
      do_access(brbp_pkg::OP_COP_WRITE, 24'h000001, 8'h00);
      do_access(brbp_pkg::OP_COP_WRITE, 24'h000002, 8'hfe);
      do_access(brbp_pkg::OP_COP_WRITE, 24'hffe003, 8'h01);
      do_access(brbp_pkg::OP_COP_READ,  24'h000000, 8'h00);
      do_access(brbp_pkg::OP_COP_READ,  24'h000002, 8'h00);
      do_access(brbp_pkg::OP_COP_READ,  24'h000003, 8'h00);
      drain();
   endtask

   // Random phases: fresh register settings per phase, random or zero gaps
   task automatic test_random();
      logic [brbp_pkg::CSR_DAT_W-1:0] raw;
      int                             gap_max;
      for (int p = 0; p < RAND_PHASES; p++) begin
         for (int i = 0; i < 7; i++) begin
            if (p == 0)
               raw = '0;
            else if (p == RAND_PHASES - 1)
               raw = '1;
            else
               raw = brbp_pkg::CSR_DAT_W'($urandom_range(0, 127));
            write_register(i[brbp_pkg::CSR_IDX_W-1:0], raw);
         end
         if (p == 3)
            write_register(CSR_UNUSED, 7'($urandom));
         // read-backs only reuse writes made under this phase's settings
         recent_writes.delete();
         gap_max = (p % 3 == 1) ? 0 : MAX_GAP;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // hold off mid-phase until the block has answered everything
            if (k == PHASE_ITEMS / 2)
               drain();
            send_request(random_request(), $urandom_range(0, gap_max));
         end
         drain();
      end
   endtask

   // Response check against the oldest projection
   always @(posedge clock) begin
      brbp_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (projected_results.size() == 0) begin
            if (n_errors < PRINT_MAX)
               $display("%0t: unexpected response read_data=%h write_blocked=%b",
                        $time, rsp_data.read_data, rsp_data.write_blocked);
            n_errors++;
         end else begin
            want = projected_results.pop_front();
            n_checked++;
            if (rsp_data.write_blocked)
               n_blocked++;
            if (rsp_data.read_data !== want.read_data) begin
               if (n_errors < PRINT_MAX)
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_data.read_data);
               n_errors++;
            end
            if (rsp_data.write_blocked !== want.write_blocked) begin
               if (n_errors < PRINT_MAX)
                  $display("%0t: write_blocked expected %b actual %b",
                           $time, want.write_blocked, rsp_data.write_blocked);
               n_errors++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      cfg_shadow = '0;
      n_sent     = 0;
      n_checked  = 0;
      n_blocked  = 0;
      n_errors   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_host_window();
      test_protection();
      test_bitmap();
      test_random();
      drain();

      $display("Covered %0d requests, %0d responses checked, %0d writes blocked;",
               n_sent, n_checked, n_blocked);
      $display("host window, protection, linear and 2/4-bit pixel access, %0d random phases",
               RAND_PHASES);
      if (n_errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/brbp_pkg.sv
sv/brbp_ram.sv
sv/brbp_decode.sv
sv/banked_ram_bitmap_projection_unit.sv
test/tb.sv
